// ===== design/hatch_toggle_sequencer_macros.svh =====
// Assertion helpers shared by the checkers of the hatch toggle sequencer.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef HATCH_TOGGLE_SEQUENCER_MACROS_SVH
`define HATCH_TOGGLE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define HTSQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define HTSQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/htsq_pkg.sv =====
`default_nettype none

package htsq_pkg;

	// Register file geometry
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_EDGE_WINDOW    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_EDGES_REQUIRED = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SETUP_DURATION = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OPEN_DWELL     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SETTLE         = 3'd4;

	localparam logic [31:0] RST_EDGE_WINDOW    = 32'd10000;
	localparam logic [3:0]  RST_EDGES_REQUIRED = 4'd4;
	localparam logic [30:0] RST_SETUP_DURATION = 31'd600000;
	localparam logic [15:0] RST_OPEN_DWELL     = 16'd100;
	localparam logic [15:0] RST_SETTLE         = 16'd200;

	// Event codes
	localparam logic [1:0] OP_SWITCH = 2'd0;
	localparam logic [1:0] OP_FEED   = 2'd1;
	localparam logic [1:0] OP_POLL   = 2'd2;

	// Servo positions
	localparam logic [1:0] POS_NONE   = 2'd0;
	localparam logic [1:0] POS_OPEN   = 2'd1;
	localparam logic [1:0] POS_HALF   = 2'd2;
	localparam logic [1:0] POS_CLOSED = 2'd3;

	// Results per event
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic [31:0] edge_window_ms;
		logic [3:0]  edges_required;
		logic [30:0] setup_duration_ms;
		logic [15:0] open_dwell_ms;
		logic [15:0] settle_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  servo_position;
		logic [15:0] servo_hold_ms;
		logic        switch_handled;
		logic        setup_active;
		logic        radio_start;
		logic        restart_request;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       fire;
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} evt_t;

endpackage

`default_nettype wire

// ===== design/htsq_regs.sv =====
`default_nettype none

module htsq_regs
	import htsq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic                 wr;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_window_ms    <= RST_EDGE_WINDOW;
			cfg_q.edges_required    <= RST_EDGES_REQUIRED;
			cfg_q.setup_duration_ms <= RST_SETUP_DURATION;
			cfg_q.open_dwell_ms     <= RST_OPEN_DWELL;
			cfg_q.settle_ms         <= RST_SETTLE;
		end else if (wr) begin
			case (idx)
				REG_EDGE_WINDOW:    cfg_q.edge_window_ms    <= pwdata;
				REG_EDGES_REQUIRED: cfg_q.edges_required    <= pwdata[3:0];
				REG_SETUP_DURATION: cfg_q.setup_duration_ms <= pwdata[30:0];
				REG_OPEN_DWELL:     cfg_q.open_dwell_ms     <= pwdata[15:0];
				REG_SETTLE:         cfg_q.settle_ms         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_EDGE_WINDOW:    prdata = cfg_q.edge_window_ms;
			REG_EDGES_REQUIRED: prdata = {28'd0, cfg_q.edges_required};
			REG_SETUP_DURATION: prdata = {1'b0, cfg_q.setup_duration_ms};
			REG_OPEN_DWELL:     prdata = {16'd0, cfg_q.open_dwell_ms};
			REG_SETTLE:         prdata = {16'd0, cfg_q.settle_ms};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/htsq_core.sv =====
`default_nettype none

module htsq_core
	import htsq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] now_ms,
	input  wire logic        switch_level,
	input  wire cfg_t        cfg,
	input  wire logic        out_free,
	output evt_t             evt
);

	localparam logic [1:0] STEP_IDLE   = 2'd0;
	localparam logic [1:0] STEP_HALF   = 2'd1;
	localparam logic [1:0] STEP_CLOSED = 2'd2;

	// Input stage
	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [31:0] now_s1;
	logic        lvl_s1;
	logic        fire;

	// Sequencer state
	logic        switch_last_q, n_switch_last;
	logic        hatch_open_q,  n_hatch_open;
	logic [1:0]  close_step_q,  n_close_step;
	logic [3:0]  edge_count_q,  n_edge_count;
	logic [31:0] window_start_q, n_window_start;
	logic [31:0] setup_until_q, n_setup_until;
	logic        armed_q,       n_armed;
	logic        radio_on_q,    n_radio_on;

	logic [31:0] win_age;
	logic        win_open;
	logic [3:0]  cnt_inc;
	logic        arm_hit;
	logic [31:0] until_diff;
	logic        setup_live;
	logic [1:0]  count;
	res_t        r0;
	res_t        r1;

	assign fire     = vld_s1 && out_free;
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= operation;
			now_s1 <= now_ms;
			lvl_s1 <= switch_level;
		end
	end

	// Gesture window and setup expiry
	assign win_age    = now_s1 - window_start_q;
	assign win_open   = (edge_count_q != 4'd0) && (win_age <= cfg.edge_window_ms);
	assign cnt_inc    = (win_open ? edge_count_q : 4'd0) + 4'd1;
	assign arm_hit    = cnt_inc >= cfg.edges_required;
	assign until_diff = setup_until_q - now_s1;
	assign setup_live = armed_q && (until_diff != 32'd0) && !until_diff[31];

	always_comb begin
		n_switch_last  = switch_last_q;
		n_hatch_open   = hatch_open_q;
		n_close_step   = close_step_q;
		n_edge_count   = edge_count_q;
		n_window_start = window_start_q;
		n_setup_until  = setup_until_q;
		n_armed        = armed_q;
		n_radio_on     = radio_on_q;
		r0             = '0;
		r1             = '0;
		count          = CNT_NONE;
		case (op_s1)
			OP_SWITCH: begin
				count   = CNT_ONE;
				r0.last = 1'b1;
				if (lvl_s1 != switch_last_q) begin
					n_switch_last     = lvl_s1;
					r0.switch_handled = 1'b1;
					if (!win_open) begin
						n_window_start = now_s1;
					end
					if (arm_hit) begin
						n_edge_count   = 4'd0;
						n_setup_until  = now_s1 + {1'b0, cfg.setup_duration_ms};
						n_armed        = 1'b1;
						n_radio_on     = 1'b1;
						r0.radio_start = !radio_on_q;
					end else begin
						n_edge_count = cnt_inc;
					end
					if (!hatch_open_q) begin
						n_hatch_open      = 1'b1;
						n_close_step      = STEP_IDLE;
						r0.servo_position = POS_OPEN;
						r0.servo_hold_ms  = cfg.settle_ms;
					end else if (close_step_q == STEP_IDLE) begin
						n_close_step      = STEP_HALF;
						r0.servo_position = POS_HALF;
						r0.servo_hold_ms  = cfg.settle_ms;
					end else if (close_step_q == STEP_HALF) begin
						n_close_step      = STEP_CLOSED;
						r0.servo_position = POS_CLOSED;
						r0.servo_hold_ms  = cfg.settle_ms;
					end else begin
						n_close_step = STEP_IDLE;
						n_hatch_open = 1'b0;
					end
				end
			end
			OP_FEED: begin
				count             = CNT_TWO;
				r0.servo_position = POS_OPEN;
				r0.servo_hold_ms  = cfg.open_dwell_ms;
				r1.servo_position = POS_CLOSED;
				r1.servo_hold_ms  = cfg.settle_ms;
				r1.last           = 1'b1;
				n_hatch_open      = 1'b0;
				n_close_step      = STEP_IDLE;
			end
			OP_POLL: begin
				count   = CNT_ONE;
				r0.last = 1'b1;
				if (setup_live) begin
					r0.setup_active = 1'b1;
				end else if (armed_q && radio_on_q) begin
					n_armed            = 1'b0;
					r0.restart_request = 1'b1;
				end else begin
					n_armed = 1'b0;
					if (win_open) begin
						r0.setup_active = 1'b1;
					end else begin
						n_edge_count = 4'd0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_last_q  <= 1'b0;
			hatch_open_q   <= 1'b0;
			close_step_q   <= STEP_IDLE;
			edge_count_q   <= 4'd0;
			window_start_q <= 32'd0;
			setup_until_q  <= 32'd0;
			armed_q        <= 1'b0;
			radio_on_q     <= 1'b0;
		end else if (fire) begin
			switch_last_q  <= n_switch_last;
			hatch_open_q   <= n_hatch_open;
			close_step_q   <= n_close_step;
			edge_count_q   <= n_edge_count;
			window_start_q <= n_window_start;
			setup_until_q  <= n_setup_until;
			armed_q        <= n_armed;
			radio_on_q     <= n_radio_on;
		end
	end

	assign evt.fire  = fire;
	assign evt.count = count;
	assign evt.r0    = r0;
	assign evt.r1    = r1;

endmodule

`default_nettype wire

// ===== design/htsq_out.sv =====
`default_nettype none

module htsq_out
	import htsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire evt_t evt,
	output logic      out_free,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic out_valid_q;
	logic pend_q;
	res_t out_res_q;
	res_t pend_res_q;
	logic slot_free;
	logic adv;
	logic load;

	assign slot_free = !out_valid_q || out_ready;
	assign adv       = pend_q && slot_free;
	assign out_free  = !pend_q && slot_free;
	assign load      = evt.fire && (evt.count != CNT_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			pend_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			pend_q      <= (evt.count == CNT_TWO);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= pend_res_q;
		end else if (load) begin
			out_res_q  <= evt.r0;
			pend_res_q <= evt.r1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

`default_nettype wire

// ===== design/hatch_toggle_sequencer.sv =====
// The event stage registers an accepted word; its first result word is loaded into
// the output register once that has room. Throughput: one word per cycle for switch
// and poll events while out_ready stays high; a feed alarm makes two result words, and
// the event stage holds its next word while the second waits in the one pending slot.
// Reset (arst_n low, asynchronous): registers return to defaults, all state
// clears, both stages empty.
`default_nettype none

module hatch_toggle_sequencer
	import htsq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// Event input
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [31:0]       now_ms,
	input  wire logic              switch_level,
	// Result output
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [1:0]        servo_position,
	output logic      [15:0]       servo_hold_ms,
	output logic                   switch_handled,
	output logic                   setup_active,
	output logic                   radio_start,
	output logic                   restart_request,
	output logic                   last
);

	cfg_t cfg;
	evt_t evt;
	logic out_free;
	res_t out_res;

	// Register file: window, edge count, setup duration and servo hold times.
	htsq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Event stage: hold the accepted word, decide its results in one pass and
	// advance the hatch, gesture and setup state when the output side has room.
	htsq_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.now_ms       (now_ms),
		.switch_level (switch_level),
		.cfg          (cfg),
		.out_free     (out_free),
		.evt          (evt)
	);

	// Output stage: result register plus a pending slot for the closed word of
	// a feed alarm, and the event stage holds its next word while one waits.
	htsq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Drive the result fields from the output register.
	assign servo_position  = out_res.servo_position;
	assign servo_hold_ms   = out_res.servo_hold_ms;
	assign switch_handled  = out_res.switch_handled;
	assign setup_active    = out_res.setup_active;
	assign radio_start     = out_res.radio_start;
	assign restart_request = out_res.restart_request;
	assign last            = out_res.last;

endmodule

`default_nettype wire

// ===== design/htsq_chk.sv =====
`default_nettype none
`include "hatch_toggle_sequencer_macros.svh"

module htsq_chk
	import htsq_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  servo_position,
	input wire logic [15:0] servo_hold_ms,
	input wire logic        switch_handled,
	input wire logic        setup_active,
	input wire logic        radio_start,
	input wire logic        restart_request,
	input wire logic        last
);

	// Hold a stalled result word.
	`HTSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(servo_position) && $stable(servo_hold_ms) && $stable(last))

	// The open word of a feed alarm is followed at once by the closed word.
	`HTSQ_ASSERT_NEXT(a_feed_pair, out_valid && out_ready && !last, out_valid && (servo_position == POS_CLOSED) && last)

	// A poll answer commands no servo and never pairs active with restart.
	`HTSQ_ASSERT_NOW(a_poll_clean, out_valid && setup_active, (servo_position == POS_NONE) && (servo_hold_ms == 16'd0) && !restart_request)

	// Radio start only comes from a handled switch edge.
	`HTSQ_ASSERT_NOW(a_radio_src, out_valid && radio_start, switch_handled && last)

endmodule

bind hatch_toggle_sequencer htsq_chk u_chk (.*);

`default_nettype wire

// ===== tb/sv/hatch_forecast_pkg.sv =====
package hatch_forecast_pkg;
	import htsq_pkg::*;

	// Predicts the servo and setup-mode words that each accepted event produces.
	class hatch_forecast;
		cfg_t        regs;
		bit          switch_last;
		bit          hatch_open;
		bit [1:0]    close_step;
		bit [3:0]    edge_count;
		bit [31:0]   window_start;
		bit [31:0]   setup_until;
		bit          setup_armed;
		bit          radio_on;
		res_t        pending_cmds[$];
		int unsigned mismatches;

		function new();
			regs = '{RST_EDGE_WINDOW, RST_EDGES_REQUIRED, RST_SETUP_DURATION,
				RST_OPEN_DWELL, RST_SETTLE};
			switch_last  = 1'b0;
			hatch_open   = 1'b0;
			close_step   = 2'd0;
			edge_count   = 4'd0;
			window_start = 32'd0;
			setup_until  = 32'd0;
			setup_armed  = 1'b0;
			radio_on     = 1'b0;
			mismatches   = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_EDGE_WINDOW:    regs.edge_window_ms    = value;
				REG_EDGES_REQUIRED: regs.edges_required    = value[3:0];
				REG_SETUP_DURATION: regs.setup_duration_ms = value[30:0];
				REG_OPEN_DWELL:     regs.open_dwell_ms     = value[15:0];
				REG_SETTLE:         regs.settle_ms         = value[15:0];
				default: ;
			endcase
		endfunction

		function res_t make_cmd(logic [1:0] pos, logic [15:0] hold, logic handled,
				logic active, logic rstart, logic restart, logic fin);
			make_cmd = '{pos, hold, handled, active, rstart, restart, fin};
		endfunction

		// Count one gesture edge; return 1 when the radio starts on it.
		function bit count_edge(bit [31:0] t);
			bit started;
			started = 1'b0;
			if (edge_count == 4'd0 || (t - window_start) > regs.edge_window_ms) begin
				window_start = t;
				edge_count   = 4'd0;
			end
			edge_count = edge_count + 4'd1;
			if (edge_count >= regs.edges_required) begin
				edge_count  = 4'd0;
				setup_until = t + {1'b0, regs.setup_duration_ms};
				setup_armed = 1'b1;
				if (!radio_on) begin
					radio_on = 1'b1;
					started  = 1'b1;
				end
			end
			return started;
		endfunction

		function void note_event(logic [1:0] op, logic [31:0] t, logic level);
			bit        started;
			bit [31:0] gap;
			case (op)
				OP_SWITCH: begin
					if (level == switch_last) begin
						pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 0, 0, 0, 0, 1));
						return;
					end
					switch_last = level;
					started = count_edge(t);
					if (!hatch_open) begin
						hatch_open = 1'b1;
						close_step = 2'd0;
						pending_cmds.push_back(make_cmd(POS_OPEN, regs.settle_ms,
							1, 0, started, 0, 1));
					end else if (close_step == 2'd0) begin
						close_step = 2'd1;
						pending_cmds.push_back(make_cmd(POS_HALF, regs.settle_ms,
							1, 0, started, 0, 1));
					end else if (close_step == 2'd1) begin
						close_step = 2'd2;
						pending_cmds.push_back(make_cmd(POS_CLOSED, regs.settle_ms,
							1, 0, started, 0, 1));
					end else begin
						close_step = 2'd0;
						hatch_open = 1'b0;
						pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 1, 0, started, 0, 1));
					end
				end
				OP_FEED: begin
					pending_cmds.push_back(make_cmd(POS_OPEN, regs.open_dwell_ms, 0, 0, 0, 0, 0));
					pending_cmds.push_back(make_cmd(POS_CLOSED, regs.settle_ms, 0, 0, 0, 0, 1));
					hatch_open = 1'b0;
					close_step = 2'd0;
				end
				OP_POLL: begin
					gap = setup_until - t;
					if (setup_armed && gap != 32'd0 && !gap[31]) begin
						pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 0, 1, 0, 0, 1));
						return;
					end
					if (setup_armed) begin
						setup_armed = 1'b0;
						if (radio_on) begin
							pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 0, 0, 0, 1, 1));
							return;
						end
					end
					if (edge_count != 4'd0 && (t - window_start) <= regs.edge_window_ms) begin
						pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 0, 1, 0, 0, 1));
						return;
					end
					edge_count = 4'd0;
					pending_cmds.push_back(make_cmd(POS_NONE, 16'd0, 0, 0, 0, 0, 1));
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: pos=%0d hold=%0d handled=%b",
						got.servo_position, got.servo_hold_ms, got.switch_handled);
				return;
			end
			want = pending_cmds.pop_front();
			if (got.servo_position !== want.servo_position ||
					got.servo_hold_ms !== want.servo_hold_ms ||
					got.switch_handled !== want.switch_handled ||
					got.setup_active !== want.setup_active ||
					got.radio_start !== want.radio_start ||
					got.restart_request !== want.restart_request ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch  expected: pos=%0d hold=%0d handled=%b active=%b",
						want.servo_position, want.servo_hold_ms, want.switch_handled,
						want.setup_active);
					$display("          radio=%b restart=%b last=%b",
						want.radio_start, want.restart_request, want.last);
					$display("          actual:   pos=%0d hold=%0d handled=%b active=%b",
						got.servo_position, got.servo_hold_ms, got.switch_handled,
						got.setup_active);
					$display("          radio=%b restart=%b last=%b",
						got.radio_start, got.restart_request, got.last);
				end
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/tb.sv =====
module tb;
	import htsq_pkg::*;
	import hatch_forecast_pkg::*;

	// The fourth event code has no meaning; the block must drop such a word.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	// Cycles to let pass after the last expected word before touching registers,
	// so that an ignored event still in flight has left the pipeline.
	localparam int DRAIN_CYCLES   = 8;
	// Cycles without any accepted word or register access before giving up.
	localparam int STALL_LIMIT    = 4000;
	localparam int EVENTS_PER_SEG = 165;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [1:0]        operation    = OP_POLL;
	logic [31:0]       now_ms       = '0;
	logic              switch_level = 1'b0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [1:0]        servo_position;
	logic [15:0]       servo_hold_ms;
	logic              switch_handled;
	logic              setup_active;
	logic              radio_start;
	logic              restart_request;
	logic              last;

	hatch_forecast sb;

	// Idle percentages of the two sides, changed per phase.
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned stuck_cycles = 0;
	// Running millisecond clock and the switch level as last sent.
	logic [31:0] clock_ms  = '0;
	logic        switch_now = 1'b0;

	hatch_toggle_sequencer u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: drop ready at random in recv_idle percent of the cycles.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// Monitor both channels at the edge; all drives are nonblocking, so the
	// values seen here are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_event(operation, now_ms, switch_level);
			if (out_valid && out_ready)
				sb.check_result('{servo_position, servo_hold_ms, switch_handled,
					setup_active, radio_start, restart_request, last});
			// Advance the watchdog only on cycles where nothing moves.
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Present one event word and hold it until the block takes it. Valid stays
	// high between back-to-back words and drops only during a random gap.
	task automatic send_event(input logic [1:0] op, input logic [31:0] t,
			input logic level);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		now_ms       <= t;
		switch_level <= level;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every expected word, then let in-flight work drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// edge that ends the access cycle. The bus then idles before the next access.
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Pick the register setting of a phase: maxima, minima, then random mixes.
	// High bits beyond a register's width are sometimes set to check masking.
	task automatic program_regs(input int seg);
		case (seg)
			1: begin
				apb_write(REG_EDGE_WINDOW, 32'hFFFF_FFFF);
				apb_write(REG_EDGES_REQUIRED, 32'h0000_000F);
				apb_write(REG_SETUP_DURATION, 32'hFFFF_FFFF);
				apb_write(REG_OPEN_DWELL, 32'h0000_FFFF);
				apb_write(REG_SETTLE, 32'hFFFF_FFFF);
			end
			2: begin
				// Zero edges required: every edge arms setup mode.
				apb_write(REG_EDGE_WINDOW, 32'd0);
				apb_write(REG_EDGES_REQUIRED, 32'hFFFF_FFF0);
				apb_write(REG_SETUP_DURATION, 32'h8000_0001);
				apb_write(REG_OPEN_DWELL, 32'd0);
				apb_write(REG_SETTLE, 32'd0);
			end
			default: begin
				apb_write(REG_EDGE_WINDOW, ($urandom_range(0, 3) == 0) ? $urandom :
					$urandom_range(0, 20000));
				apb_write(REG_EDGES_REQUIRED, ($urandom_range(0, 3) == 0) ?
					$urandom : $urandom_range(1, 6));
				apb_write(REG_SETUP_DURATION, ($urandom_range(0, 3) == 0) ? $urandom :
					$urandom_range(1, 5000));
				apb_write(REG_OPEN_DWELL, $urandom);
				apb_write(REG_SETTLE, $urandom);
			end
		endcase
	endtask

	// Directed opening at reset settings: a full gesture and close sequence,
	// a feed in the middle of a sequence, expiry exactly at the deadline, a
	// window across the timestamp wrap, and expiry half a wrap later.
	task automatic directed_events();
		send_event(OP_POLL, 32'd0, 1'b0);
		send_event(OP_SWITCH, 32'd5, 1'b0);           // no level change
		send_event(OP_SWITCH, 32'd10, 1'b1);          // open, first edge
		send_event(OP_SWITCH, 32'd20, 1'b0);          // half closed
		send_event(OP_POLL, 32'd30, 1'b1);            // gesture window active
		send_event(OP_SWITCH, 32'd40, 1'b1);          // closed
		send_event(OP_SWITCH, 32'd50, 1'b0);          // finished, arms setup, radio on
		send_event(OP_POLL, 32'd60, 1'b0);            // setup active
		send_event(OP_FEED, 32'd70, 1'b0);
		send_event(OP_SWITCH, 32'd80, 1'b1);          // open again
		send_event(OP_FEED, 32'd90, 1'b1);            // resets the sequence
		send_event(OP_UNKNOWN, 32'd100, 1'b0);
		send_event(OP_POLL, 32'd600050, 1'b0);        // deadline reached: restart
		send_event(OP_POLL, 32'd600051, 1'b1);        // stale window cleared
		send_event(OP_SWITCH, 32'hFFFF_FFF0, 1'b0);
		send_event(OP_SWITCH, 32'h0000_0005, 1'b1);   // edge across the wrap
		send_event(OP_POLL, 32'hFFFF_FFFF, 1'b0);
		send_event(OP_SWITCH, 32'h0000_0010, 1'b0);
		send_event(OP_SWITCH, 32'h0000_0020, 1'b1);   // re-arms, no second start
		send_event(OP_POLL, 32'h20 + 32'd600000 - 32'd1, 1'b1);
		send_event(OP_POLL, 32'h20 + 32'd600000 + 32'h8000_0000, 1'b0);
		send_event(OP_SWITCH, 32'h0000_0030, 1'b1);   // no level change
		send_event(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
		send_event(OP_POLL, 32'd0, 1'b1);
		switch_now = 1'b1;
		clock_ms   = 32'h0000_0040;
	endtask

	// Mostly gesture-like traffic: level toggles close together in time, with
	// polls and feeds mixed in; now and then a long jump or a random timestamp
	// to carry setup mode past expiry. Ignored words are not counted.
	task automatic random_events(input int count);
		int          sent;
		int unsigned pick;
		logic [1:0]  op;
		logic        level;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				clock_ms = clock_ms + $urandom_range(0, 40);
			else if (pick < 90)
				clock_ms = clock_ms + $urandom_range(0, 4000);
			else if (pick < 98)
				clock_ms = clock_ms + $urandom_range(0, 32'h0020_0000);
			else
				clock_ms = $urandom;
			pick  = $urandom_range(0, 99);
			level = 1'($urandom_range(0, 1));
			if (pick < 50) begin
				op         = OP_SWITCH;
				switch_now = !switch_now;
				level      = switch_now;
			end else if (pick < 58) begin
				op    = OP_SWITCH;
				level = switch_now;
			end else if (pick < 68) begin
				op = OP_FEED;
			end else if (pick < 92) begin
				op = OP_POLL;
			end else begin
				op = OP_UNKNOWN;
			end
			send_event(op, clock_ms, level);
			if (op != OP_UNKNOWN)
				sent++;
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Two register settings per idle profile: sender idles 27 and receiver
		// 62 percent, then the other way round, then neither idles.
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle = 27;
					recv_idle = 62;
				end
				1: begin
					send_idle = 62;
					recv_idle = 27;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			if (seg == 0) begin
				directed_events();
			end else begin
				settle();
				program_regs(seg);
			end
			random_events(EVENTS_PER_SEG);
		end
		settle();
		if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== hatch_toggle_sequencer.f =====
+incdir+design
design/htsq_pkg.sv
design/htsq_regs.sv
design/htsq_core.sv
design/htsq_out.sv
design/hatch_toggle_sequencer.sv
design/htsq_chk.sv
tb/sv/hatch_forecast_pkg.sv
tb/sv/tb.sv
